@@ sv/crc8d_pkg.sv @@
`default_nettype none

package crc8d_pkg;

  // Frame parser phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_LEN_LO   = 6'b000010,
    PH_LEN_HI   = 6'b000100,
    PH_HEAD_CRC = 6'b001000,
    PH_DATA     = 6'b010000,
    PH_BODY_CRC = 6'b100000
  } phase_t;

  // Result kinds
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_STORED    = 3'd0;
  localparam kind_t KIND_LINE      = 3'd1;
  localparam kind_t KIND_OK        = 3'd2;
  localparam kind_t KIND_CRC_ERR   = 3'd3;
  localparam kind_t KIND_TOO_LARGE = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_BYTE   = 2'd0;
  localparam cfg_idx_t CFG_CRC_POLY     = 2'd1;
  localparam cfg_idx_t CFG_BUFFER_LIMIT = 2'd2;

  localparam logic [7:0]  NEWLINE_BYTE       = 8'h0A;
  localparam logic [7:0]  CRC_INIT           = 8'h00;
  localparam logic [7:0]  START_BYTE_RST     = 8'h55;
  localparam logic [7:0]  CRC_POLY_RST       = 8'h07;
  localparam logic [15:0] BUFFER_LIMIT_RST   = 16'd256;

  // One byte of MSB-first CRC-8
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] poly,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/crc8_packet_deframer.sv @@
`default_nettype none
// Latency: a result word appears on out_* the cycle after its byte is accepted.
// Throughput: one byte per cycle while no result is held back; the CRC-8 update
// and phase decode are combinational between parser state and result register.
// A byte is taken whenever the result register is empty or drained that cycle.
// Reset (rst_n low, synchronous): parser idle, counts and CRC cleared,
// registers back to start 0x55, poly 0x07, limit 256; no result pending.

module crc8_packet_deframer (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire crc8d_pkg::cfg_idx_t cfg_index,
  input  wire [15:0]              cfg_wdata,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [7:0]               in_rx_byte,
  output logic                    out_valid,
  input  wire                     out_ready,
  output crc8d_pkg::kind_t        out_kind,
  output logic [7:0]              out_byte_value,
  output logic [15:0]             out_byte_index,
  output logic [15:0]             out_length
);
  import crc8d_pkg::*;

  logic [7:0]  start_byte_r;
  logic [7:0]  crc_poly_r;
  logic [15:0] buffer_limit_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] position_r, position_nxt;
  logic [7:0]  crc_r, crc_nxt;

  logic        out_valid_r;
  kind_t       kind_r;
  logic [7:0]  byte_value_r;
  logic [15:0] byte_index_r, length_r;

  logic        emit;
  kind_t       kind_nxt;
  logic [7:0]  byte_value_nxt;
  logic [15:0] byte_index_nxt, length_nxt;

  logic        in_fire;
  logic [7:0]  crc_upd;
  logic [15:0] pos_inc;
  logic [16:0] count_inc;
  logic [15:0] len_full;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Datapath pieces factored out of the parser
  assign crc_upd   = crc8_next(phase_r == PH_LEN_LO ? CRC_INIT : crc_r, crc_poly_r, in_rx_byte);
  assign pos_inc   = position_r + 16'd1;
  assign count_inc = {1'b0, count_r} + 17'd1;
  assign len_full  = count_r | {in_rx_byte, 8'h00};

  // Parser next state and result word
  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    position_nxt   = position_r;
    crc_nxt        = crc_r;
    emit           = 1'b0;
    kind_nxt       = KIND_STORED;
    byte_value_nxt = 8'h00;
    byte_index_nxt = 16'h0000;
    length_nxt     = 16'h0000;
    case (phase_r)
      PH_LEN_LO: begin
        count_nxt = {8'h00, in_rx_byte};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len_full > buffer_limit_r) begin
          phase_nxt  = PH_IDLE;
          count_nxt  = 16'h0000;
          emit       = 1'b1;
          kind_nxt   = KIND_TOO_LARGE;
          length_nxt = len_full;
        end else begin
          count_nxt    = len_full;
          position_nxt = 16'h0000;
          crc_nxt      = crc_upd;
          phase_nxt    = PH_HEAD_CRC;
        end
      end
      PH_HEAD_CRC: begin
        if (crc_r == in_rx_byte) begin
          phase_nxt = (count_r == 16'h0000) ? PH_BODY_CRC : PH_DATA;
        end else begin
          phase_nxt = PH_IDLE;
          count_nxt = 16'h0000;
        end
      end
      PH_DATA: begin
        crc_nxt        = crc_upd;
        position_nxt   = pos_inc;
        if (pos_inc >= count_r) phase_nxt = PH_BODY_CRC;
        emit           = 1'b1;
        kind_nxt       = KIND_STORED;
        byte_value_nxt = in_rx_byte;
        byte_index_nxt = position_r;
      end
      PH_BODY_CRC: begin
        phase_nxt  = PH_IDLE;
        count_nxt  = 16'h0000;
        emit       = 1'b1;
        kind_nxt   = (crc_r == in_rx_byte) ? KIND_OK : KIND_CRC_ERR;
        length_nxt = count_r;
      end
      default: begin
        // Text line handling outside frames, and start byte detection
        phase_nxt = PH_IDLE;
        if (in_rx_byte == start_byte_r) begin
          phase_nxt = PH_LEN_LO;
          if (count_r != 16'h0000) begin
            count_nxt  = 16'h0000;
            emit       = 1'b1;
            kind_nxt   = KIND_LINE;
            length_nxt = count_r;
          end
        end else if (count_inc >= {1'b0, buffer_limit_r} || in_rx_byte == NEWLINE_BYTE) begin
          count_nxt  = 16'h0000;
          emit       = 1'b1;
          kind_nxt   = KIND_LINE;
          length_nxt = count_r;
        end else begin
          count_nxt      = count_inc[15:0];
          emit           = 1'b1;
          kind_nxt       = KIND_STORED;
          byte_value_nxt = in_rx_byte;
          byte_index_nxt = count_r;
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= START_BYTE_RST;
      crc_poly_r     <= CRC_POLY_RST;
      buffer_limit_r <= BUFFER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:   start_byte_r   <= cfg_wdata[7:0];
        CFG_CRC_POLY:     crc_poly_r     <= cfg_wdata[7:0];
        CFG_BUFFER_LIMIT: buffer_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      count_r    <= 16'h0000;
      position_r <= 16'h0000;
      crc_r      <= 8'h00;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      position_r <= position_nxt;
      crc_r      <= crc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_r       <= kind_nxt;
      byte_value_r <= byte_value_nxt;
      byte_index_r <= byte_index_nxt;
      length_r     <= length_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte_value = byte_value_r;
  assign out_byte_index = byte_index_r;
  assign out_length     = length_r;

endmodule

`default_nettype wire
